>>> design/tcrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcrm_pkg
// Shared types, widths, stage map and rounding helper for the tilted camera
// range map pipeline.
// ----------------------------------------------------------------------------
package tcrm_pkg;

    localparam int COLS = 1024;
    localparam int ROWS = 1024;

    // Datapath widths, sized for image dimensions up to 8192.
    localparam int CTW  = 15;   // doubled, centered pixel index, signed
    localparam int TW   = 16;   // trig register, Q2.14 signed
    localparam int CW   = 24;   // altitude, focal length, step registers
    localparam int LW   = 18;   // rounded basis terms and D0, K1, signed
    localparam int K2W  = 20;   // K2, signed
    localparam int IW   = 39;   // doubled sensor coordinate, signed
    localparam int MW   = 37;   // magnitude of a sensor coordinate
    localparam int MLO  = 19;   // low part of a split operand
    localparam int MHI  = MW - MLO;
    localparam int FW   = CW + 1;
    localparam int ADW  = CW + LW - 1;
    localparam int DENW = 58;   // denominator, signed
    localparam int DW   = DENW - 1;
    localparam int SQW  = 76;   // sum of squares
    localparam int SRW  = SQW / 2;
    localparam int PW   = ADW + SRW;
    localparam int QW   = 32;
    localparam int RW   = 34;   // exact Q28 products before rounding

    // Stage map.
    localparam int SQN    = SRW;
    localparam int DVN    = QW;
    localparam int ST_SQ  = 5;
    localparam int ST_MA  = ST_SQ + SQN;
    localparam int ST_MB  = ST_MA + 1;
    localparam int ST_OV  = ST_MB + 1;
    localparam int ST_DV  = ST_OV + 1;
    localparam int ST_OUT = ST_DV + DVN;
    localparam int NST    = ST_OUT + 1;

    typedef struct packed {
        logic [9:0] column;
        logic [9:0] row;
    } t_in;

    typedef struct packed {
        logic [31:0] range_out;
        logic        invalid;
    } t_out;

    typedef struct packed {
        logic [ADW-1:0] ad;
        logic [DW-1:0]  dmag;
        logic           dz;
    } t_side;

    typedef enum logic [2:0] {
        REG_SIN_NEG_PITCH,
        REG_COS_PITCH,
        REG_SIN_ROLL,
        REG_COS_ROLL,
        REG_ALTITUDE,
        REG_FOCAL_LENGTH,
        REG_STEP_X,
        REG_STEP_Y
    } t_reg_idx;

    // Q28 to Q14, round to nearest with ties toward plus infinity.
    function automatic logic signed [RW-1:0] rnd14(input logic signed [RW-1:0] x);
        logic signed [RW-1:0] y;
        y = x + RW'(8192);
        return y >>> 14;
    endfunction

endpackage

>>> design/tcrm_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcrm_sqrt
// Pipelined integer square root, one result bit per stage, with a sideband
// that travels alongside.
// ----------------------------------------------------------------------------
module tcrm_sqrt (
    input  logic                        i_clk,
    input  logic [tcrm_pkg::SQN-1:0]    i_en,
    input  logic [tcrm_pkg::SQW-1:0]    i_s2,
    input  tcrm_pkg::t_side             i_side,
    output logic [tcrm_pkg::SRW-1:0]    o_root,
    output tcrm_pkg::t_side             o_side
);
    import tcrm_pkg::*;

    logic [SQW-1:0] r_rem  [SQN];
    logic [SRW-1:0] r_root [SQN];
    t_side          r_side [SQN];

    for (genvar t = 0; t < SQN; t++) begin : g_st
        localparam int K = SQN - 1 - t;
        logic [SQW-1:0]   rem_in;
        logic [SRW-1:0]   root_in;
        t_side            side_in;
        logic [SQW+1:0]   trial;

        if (t == 0) begin : g_first
            assign rem_in  = i_s2;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[t-1];
            assign root_in = r_root[t-1];
            assign side_in = r_side[t-1];
        end

        // (r + 2^k)^2 - r^2, with no root bits at or below k yet.
        assign trial = ((SQW+2)'(root_in) << (K + 1)) | ((SQW+2)'(1) << (2 * K));

        always_ff @(posedge i_clk) begin
            if (i_en[t]) begin
                r_side[t] <= side_in;
                if ((SQW+2)'(rem_in) >= trial) begin
                    r_rem[t]  <= rem_in - trial[SQW-1:0];
                    r_root[t] <= root_in | (SRW'(1) << K);
                end else begin
                    r_rem[t]  <= rem_in;
                    r_root[t] <= root_in;
                end
            end
        end
    end

    assign o_root = r_root[SQN-1];
    assign o_side = r_side[SQN-1];

endmodule

>>> design/tcrm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcrm_div
// Pipelined restoring divider for a quotient known to fit in 32 bits, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module tcrm_div (
    input  logic                        i_clk,
    input  logic [tcrm_pkg::DVN-1:0]    i_en,
    input  logic [tcrm_pkg::PW-1:0]     i_p,
    input  logic [tcrm_pkg::DW-1:0]     i_dmag,
    input  logic                        i_bad,
    output logic [tcrm_pkg::QW-1:0]     o_q,
    output logic                        o_bad
);
    import tcrm_pkg::*;

    logic [PW-1:0] r_rem  [DVN];
    logic [QW-1:0] r_q    [DVN];
    logic [DW-1:0] r_dmag [DVN];
    logic          r_bad  [DVN];

    for (genvar t = 0; t < DVN; t++) begin : g_st
        localparam int B = DVN - 1 - t;
        logic [PW-1:0]    rem_in;
        logic [QW-1:0]    q_in;
        logic [DW-1:0]    dmag_in;
        logic             bad_in;
        logic [DW+QW-1:0] sub;

        if (t == 0) begin : g_first
            assign rem_in  = i_p;
            assign q_in    = '0;
            assign dmag_in = i_dmag;
            assign bad_in  = i_bad;
        end else begin : g_next
            assign rem_in  = r_rem[t-1];
            assign q_in    = r_q[t-1];
            assign dmag_in = r_dmag[t-1];
            assign bad_in  = r_bad[t-1];
        end

        assign sub = (DW+QW)'(dmag_in) << B;

        always_ff @(posedge i_clk) begin
            if (i_en[t]) begin
                r_dmag[t] <= dmag_in;
                r_bad[t]  <= bad_in;
                if ((DW+QW)'(rem_in) >= sub) begin
                    r_rem[t] <= rem_in - sub[PW-1:0];
                    r_q[t]   <= q_in | (QW'(1) << B);
                end else begin
                    r_rem[t] <= rem_in;
                    r_q[t]   <= q_in;
                end
            end
        end
    end

    assign o_q   = r_q[DVN-1];
    assign o_bad = r_bad[DVN-1];

endmodule

>>> design/tilted_camera_range_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilted_camera_range_map
// Slant range from a tilted pinhole camera to a flat substrate, per pixel.
//
//  Channel   Signals                          Beat
//  input     i_in_valid / o_in_ready          t_in: column, row
//  output    o_out_valid / i_out_ready        t_out: range_out, invalid
//  config    psel penable pwrite paddr pwdata 8 registers at 4*index
//
// One beat per cycle from input to output while the output is not stalled.
// The pipeline holds the 38-stage square root and the 32-stage divider.
// Reset clears the stage valid bits and loads the register defaults.
// Each stage moves when it is empty or the stage after it moves, so a stall
// at the output fills bubbles before it holds the input.
// ----------------------------------------------------------------------------
module tilted_camera_range_map (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tcrm_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tcrm_pkg::t_out    o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import tcrm_pkg::*;

    // Configuration registers.
    logic signed [TW-1:0] r_snp, r_cp, r_sr, r_cr;
    logic [CW-1:0]        r_alt, r_foc, r_stx, r_sty;
    t_reg_idx             w_idx;
    logic [FW-1:0]        w_f2;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_f2   = {r_foc, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snp <= '0;
            r_cp  <= TW'(16384);
            r_sr  <= '0;
            r_cr  <= TW'(16384);
            r_alt <= CW'(256);
            r_foc <= CW'(65536);
            r_stx <= CW'(64);
            r_sty <= CW'(64);
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_SIN_NEG_PITCH: r_snp <= pwdata[TW-1:0];
                REG_COS_PITCH:     r_cp  <= pwdata[TW-1:0];
                REG_SIN_ROLL:      r_sr  <= pwdata[TW-1:0];
                REG_COS_ROLL:      r_cr  <= pwdata[TW-1:0];
                REG_ALTITUDE:      r_alt <= pwdata[CW-1:0];
                REG_FOCAL_LENGTH:  r_foc <= pwdata[CW-1:0];
                REG_STEP_X:        r_stx <= pwdata[CW-1:0];
                REG_STEP_Y:        r_sty <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SIN_NEG_PITCH: prdata = 32'(unsigned'(r_snp));
            REG_COS_PITCH:     prdata = 32'(unsigned'(r_cp));
            REG_SIN_ROLL:      prdata = 32'(unsigned'(r_sr));
            REG_COS_ROLL:      prdata = 32'(unsigned'(r_cr));
            REG_ALTITUDE:      prdata = 32'(r_alt);
            REG_FOCAL_LENGTH:  prdata = 32'(r_foc);
            REG_STEP_X:        prdata = 32'(r_stx);
            REG_STEP_Y:        prdata = 32'(r_sty);
            default:           prdata = '0;
        endcase
    end

    // Stage valid bits and the move enables that ripple back from the output.
    logic [NST-1:0] r_v;
    logic [NST-1:0] en;

    assign en[NST-1] = !r_v[NST-1] || i_out_ready;
    for (genvar k = 0; k < NST - 1; k++) begin : g_en
        assign en[k] = !r_v[k] || en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (en & {r_v[NST-2:0], i_in_valid}) | (~en & r_v);
        end
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_v[NST-1];

    // Stage 0: centered pixel indices and first rotated basis terms.
    logic signed [CTW-1:0] n_ctc, n_ctr, r0_ctc, r0_ctr;
    logic signed [LW-1:0]  r0_l, r0_n, r0_d0, r0_k1;

    assign n_ctc = $signed({{(CTW-11){1'b0}}, i_in_data.column, 1'b0}) - CTW'(COLS - 1);
    assign n_ctr = $signed({{(CTW-11){1'b0}}, i_in_data.row, 1'b0}) - CTW'(ROWS - 1);

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_ctc <= n_ctc;
            r0_ctr <= n_ctr;
            r0_l   <= LW'(rnd14(-(RW'(r_sr) * RW'(r_snp))));
            r0_n   <= LW'(rnd14(RW'(r_cr) * RW'(r_snp)));
            r0_d0  <= LW'(rnd14(RW'(r_cr) * RW'(r_cp)));
            r0_k1  <= LW'(rnd14(-(RW'(r_cp) * RW'(r_sr))));
        end
    end

    // Stage 1: sensor coordinates, K2, altitude times |D0|.
    logic signed [IW-1:0]  r1_i2, r1_j2;
    logic signed [K2W-1:0] r1_k2;
    logic signed [LW-1:0]  r1_d0, r1_k1;
    logic [ADW-1:0]        r1_ad;
    logic [LW-2:0]         n_d0mag;

    assign n_d0mag = (r0_d0 < 0) ? (LW-1)'(-r0_d0) : (LW-1)'(r0_d0);

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_i2 <= IW'((IW+1)'(r0_ctc) * (IW+1)'($signed({1'b0, r_stx})));
            r1_j2 <= IW'((IW+1)'(r0_ctr) * (IW+1)'($signed({1'b0, r_sty})));
            r1_k2 <= K2W'(rnd14(RW'(r_cr) * RW'(r0_n) - RW'(r0_l) * RW'(r_sr)));
            r1_d0 <= r0_d0;
            r1_k1 <= r0_k1;
            r1_ad <= ADW'(r_alt) * ADW'(n_d0mag);
        end
    end

    // Stage 2: denominator products and split squares.
    logic [MW-1:0]          n_ia, n_ja;
    logic signed [DENW-1:0] r2_pi, r2_pj, r2_pf;
    logic [2*MHI-1:0]       r2_ihh, r2_jhh;
    logic [MHI+MLO-1:0]     r2_ihl, r2_jhl;
    logic [2*MLO-1:0]       r2_ill, r2_jll;
    logic [2*FW-1:0]        r2_ff;
    logic [ADW-1:0]         r2_ad;

    assign n_ia = (r1_i2 < 0) ? MW'(-r1_i2) : MW'(r1_i2);
    assign n_ja = (r1_j2 < 0) ? MW'(-r1_j2) : MW'(r1_j2);

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_pi  <= DENW'(r1_i2) * DENW'(r1_k1);
            r2_pj  <= DENW'(r1_j2) * DENW'(r1_k2);
            r2_pf  <= DENW'($signed({1'b0, w_f2})) * DENW'(r1_d0);
            r2_ihh <= (2*MHI)'(n_ia[MW-1:MLO]) * (2*MHI)'(n_ia[MW-1:MLO]);
            r2_ihl <= (MHI+MLO)'(n_ia[MW-1:MLO]) * (MHI+MLO)'(n_ia[MLO-1:0]);
            r2_ill <= (2*MLO)'(n_ia[MLO-1:0]) * (2*MLO)'(n_ia[MLO-1:0]);
            r2_jhh <= (2*MHI)'(n_ja[MW-1:MLO]) * (2*MHI)'(n_ja[MW-1:MLO]);
            r2_jhl <= (MHI+MLO)'(n_ja[MW-1:MLO]) * (MHI+MLO)'(n_ja[MLO-1:0]);
            r2_jll <= (2*MLO)'(n_ja[MLO-1:0]) * (2*MLO)'(n_ja[MLO-1:0]);
            r2_ff  <= (2*FW)'(w_f2) * (2*FW)'(w_f2);
            r2_ad  <= r1_ad;
        end
    end

    // Stage 3: denominator and the two sensor squares.
    logic signed [DENW-1:0] r3_den;
    logic [SQW-1:0]         r3_isq, r3_jsq;
    logic [2*FW-1:0]        r3_ff;
    logic [ADW-1:0]         r3_ad;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_den <= r2_pj + r2_pf - r2_pi;
            r3_isq <= (SQW'(r2_ihh) << (2 * MLO)) + (SQW'(r2_ihl) << (MLO + 1))
                      + SQW'(r2_ill);
            r3_jsq <= (SQW'(r2_jhh) << (2 * MLO)) + (SQW'(r2_jhl) << (MLO + 1))
                      + SQW'(r2_jll);
            r3_ff  <= r2_ff;
            r3_ad  <= r2_ad;
        end
    end

    // Stage 4: sum of squares and denominator magnitude.
    logic [SQW-1:0] r4_s2;
    t_side          r4_side;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_s2        <= r3_isq + r3_jsq + SQW'(r3_ff);
            r4_side.ad   <= r3_ad;
            r4_side.dmag <= (r3_den < 0) ? DW'(-r3_den) : DW'(r3_den);
            r4_side.dz   <= (r3_den == '0);
        end
    end

    logic [SRW-1:0] sq_root;
    t_side          sq_side;

    tcrm_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en[ST_SQ +: SQN]),
        .i_s2   (r4_s2),
        .i_side (r4_side),
        .o_root (sq_root),
        .o_side (sq_side)
    );

    // Numerator altitude * |D0| * S, split over two stages.
    logic [ADW+MLO-1:0]     r_pa_lo;
    logic [ADW+SRW-MLO-1:0] r_pa_hi;
    logic [DW-1:0]          r_ma_dmag, r_mb_dmag;
    logic                   r_ma_dz, r_mb_dz;
    logic [PW-1:0]          r_mb_p;

    always_ff @(posedge i_clk) begin
        if (en[ST_MA]) begin
            r_pa_lo   <= (ADW+MLO)'(sq_side.ad) * (ADW+MLO)'(sq_root[MLO-1:0]);
            r_pa_hi   <= (ADW+SRW-MLO)'(sq_side.ad) * (ADW+SRW-MLO)'(sq_root[SRW-1:MLO]);
            r_ma_dmag <= sq_side.dmag;
            r_ma_dz   <= sq_side.dz;
        end
        if (en[ST_MB]) begin
            r_mb_p    <= (PW'(r_pa_hi) << MLO) + PW'(r_pa_lo);
            r_mb_dmag <= r_ma_dmag;
            r_mb_dz   <= r_ma_dz;
        end
    end

    // The quotient overflows 32 bits exactly when p >= |den| * 2^32.
    logic [PW-1:0] r_ov_p;
    logic [DW-1:0] r_ov_dmag;
    logic          r_ov_bad;

    always_ff @(posedge i_clk) begin
        if (en[ST_OV]) begin
            r_ov_p    <= r_mb_p;
            r_ov_dmag <= r_mb_dmag;
            r_ov_bad  <= r_mb_dz || ((DW+QW)'(r_mb_p) >= {r_mb_dmag, {QW{1'b0}}});
        end
    end

    logic [QW-1:0] dv_q;
    logic          dv_bad;

    tcrm_div u_div (
        .i_clk  (i_clk),
        .i_en   (en[ST_DV +: DVN]),
        .i_p    (r_ov_p),
        .i_dmag (r_ov_dmag),
        .i_bad  (r_ov_bad),
        .o_q    (dv_q),
        .o_bad  (dv_bad)
    );

    t_out r_out;

    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            r_out.range_out <= dv_bad ? '1 : dv_q;
            r_out.invalid   <= dv_bad;
        end
    end

    assign o_out_data = r_out;

    // An empty output stage means every stage can move.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while the output stage is empty");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_v[0])
        else $error("accepted beat did not enter the first stage");

endmodule

>>> bench/tilted_camera_range_map_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilted_camera_range_map_test
// Streams pixel coordinates through the range map under several camera
// settings, with random gaps and stalls, and checks every range beat against
// an exact fixed-point computation of the slant range.
// ----------------------------------------------------------------------------
module tilted_camera_range_map_test;
    import tcrm_pkg::*;

    localparam int LATENCY   = 79;
    localparam int MAX_CYCLE = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tilted_camera_range_map uut (.*);

    // Camera settings as seen by the range computation.
    logic signed [15:0] cam_snp, cam_cp, cam_sr, cam_cr;
    logic [23:0]        cam_alt, cam_focal, cam_sx, cam_sy;

    t_in  pixel_q[$];
    t_out range_q[$];
    int   mismatches;
    int   cycle_count;
    bit   quiet_phase;
    bit   in_taken;
    int   hold_off;
    int   send_gap;
    int   take_gap;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic longint round_q14(input longint x);
        longint y;
        y = x + 8192;
        return y >>> 14;
    endfunction

    function automatic t_out slant_range(input t_in px);
        longint     l_t, n_t, d0, k1, k2, i2, j2, f2, den;
        logic [127:0] s2, s, p, q, c;
        t_out       r;
        l_t = round_q14(-(longint'(cam_sr) * longint'(cam_snp)));
        n_t = round_q14(longint'(cam_cr) * longint'(cam_snp));
        d0  = round_q14(longint'(cam_cr) * longint'(cam_cp));
        k1  = round_q14(-(longint'(cam_cp) * longint'(cam_sr)));
        k2  = round_q14(longint'(cam_cr) * n_t - l_t * longint'(cam_sr));
        i2  = (2 * longint'(px.column) - (COLS - 1)) * longint'(cam_sx);
        j2  = (2 * longint'(px.row) - (ROWS - 1)) * longint'(cam_sy);
        f2  = 2 * longint'(cam_focal);
        den = -i2 * k1 + j2 * k2 + f2 * d0;
        if (den == 0) begin
            r.range_out = '1;
            r.invalid   = 1'b1;
            return r;
        end
        s2 = 128'(i2 < 0 ? -i2 : i2) * 128'(i2 < 0 ? -i2 : i2)
           + 128'(j2 < 0 ? -j2 : j2) * 128'(j2 < 0 ? -j2 : j2)
           + 128'(f2) * 128'(f2);
        s = '0;
        for (int k = 39; k >= 0; k--) begin
            c = s | (128'(1) << k);
            if (c * c <= s2)
                s = c;
        end
        p = 128'(cam_alt) * 128'(d0 < 0 ? -d0 : d0) * s;
        q = p / 128'(den < 0 ? -den : den);
        if (q > 128'hFFFF_FFFF) begin
            r.range_out = '1;
            r.invalid   = 1'b1;
        end else begin
            r.range_out = q[31:0];
            r.invalid   = 1'b0;
        end
        return r;
    endfunction

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 2;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SIN_NEG_PITCH: cam_snp   = value[15:0];
            REG_COS_PITCH:     cam_cp    = value[15:0];
            REG_SIN_ROLL:      cam_sr    = value[15:0];
            REG_COS_ROLL:      cam_cr    = value[15:0];
            REG_ALTITUDE:      cam_alt   = value[23:0];
            REG_FOCAL_LENGTH:  cam_focal = value[23:0];
            REG_STEP_X:        cam_sx    = value[23:0];
            default:           cam_sy    = value[23:0];
        endcase
    endtask

    task automatic set_camera(input int snp, input int cp, input int sr, input int cr,
                              input int alt, input int focal, input int sx, input int sy);
        apb_write(REG_SIN_NEG_PITCH, 32'(snp));
        apb_write(REG_COS_PITCH, 32'(cp));
        apb_write(REG_SIN_ROLL, 32'(sr));
        apb_write(REG_COS_ROLL, 32'(cr));
        apb_write(REG_ALTITUDE, 32'(alt));
        apb_write(REG_FOCAL_LENGTH, 32'(focal));
        apb_write(REG_STEP_X, 32'(sx));
        apb_write(REG_STEP_Y, 32'(sy));
    endtask

    task automatic queue_pixel(input int col, input int row);
        t_in px;
        px.column = 10'(col);
        px.row    = 10'(row);
        pixel_q.push_back(px);
    endtask

    task automatic drain;
        while (pixel_q.size() != 0 || range_q.size() != 0 || i_in_valid)
            @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    task automatic random_pixels(input int count);
        for (int k = 0; k < count; k++)
            queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
    endtask

    // Driver: the expected range is computed when the beat is accepted.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            range_q.push_back(slant_range(i_in_data));
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                send_gap   <= $urandom_range(0, 3);
                i_in_valid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
                i_in_data  <= pixel_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor, with random stalls and one long hold-off.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off    <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else if (take_gap > 0) begin
            take_gap    <= take_gap - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            take_gap    <= $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (range_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected range beat %h", o_out_data);
            end else begin
                want = range_q.pop_front();
                if (want.range_out !== o_out_data.range_out
                    || want.invalid !== o_out_data.invalid) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("range mismatch: expected %h/%b, got %h/%b",
                                 want.range_out, want.invalid,
                                 o_out_data.range_out, o_out_data.invalid);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLE) begin
            $display("tilted_camera_range_map_test NOT OK");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatches = 0; cycle_count = 0; quiet_phase = 0;
        hold_off = 0; send_gap = 0; take_gap = 0;
        cam_snp = 0; cam_cp = 16384; cam_sr = 0; cam_cr = 16384;
        cam_alt = 256; cam_focal = 65536; cam_sx = 64; cam_sy = 64;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset defaults: corners, center and the extremes of both fields.
        queue_pixel(0, 0); queue_pixel(1023, 1023); queue_pixel(0, 1023);
        queue_pixel(1023, 0); queue_pixel(511, 512); queue_pixel(512, 511);
        queue_pixel(682, 341); queue_pixel(341, 682);
        drain();

        // Straight down with nothing in the denominator: every pixel is flagged.
        set_camera(0, 0, 0, 16384, 256, 65536, 64, 64);
        queue_pixel(0, 0); queue_pixel(1023, 1023);
        drain();

        // Tilted so the ray leaves the plane on one side, plus overflow.
        set_camera(-11585, 11585, 8192, 14189, 16777215, 1, 16777215, 16777215);
        queue_pixel(0, 0); queue_pixel(1023, 1023); queue_pixel(511, 0);
        queue_pixel(0, 511);
        drain();

        // Inconsistent trig at the register extremes, zero steps, then a zero x step.
        set_camera(-16384, -16384, 16384, -16384, 0, 16777215, 0, 0);
        queue_pixel(5, 900); queue_pixel(1023, 0);
        drain();
        set_camera(16384, 16384, -16384, 16384, 16777215, 16777215, 0, 16777215);
        queue_pixel(5, 900); queue_pixel(700, 1023);
        drain();

        // Long hold-off while pixels keep coming, so the pipeline backs up.
        set_camera(-5000, 15600, 3000, 16100, 12800, 131072, 300, 300);
        random_pixels(200);
        hold_off = 300;
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            set_camera($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                       $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
                       $urandom_range(0, 24'hFFFFFF), $urandom_range(1, 24'hFFFFFF),
                       $urandom_range(0, 2000), $urandom_range(0, 2000));
            if (phase == 5)
                quiet_phase = 1;
            random_pixels(260);
            drain();
        end

        if (mismatches == 0 && range_q.size() == 0)
            $display("tilted_camera_range_map_test OK");
        else
            $display("tilted_camera_range_map_test NOT OK");
        $finish;
    end

endmodule
